/* rtl/ray_box_slab_intersection_macros.svh */
// Assertion macros shared by the ray/box slab test RTL
`ifndef RAY_BOX_SLAB_INTERSECTION_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define RBSI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbsi assertion failed");

// next-cycle implication, disabled during reset
`define RBSI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbsi assertion failed");

`endif

/* rtl/rbsi_pkg.sv */
// Package: constants, register codes and stage enable types for the slab test
package rbsi_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int CFG_IDX_BITS   = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LOW_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LOW_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LOW_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HIGH_X = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HIGH_Y = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_HIGH_Z = 3'd5;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } slab_en_t;

  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } merge_en_t;

endpackage

/* rtl/ray_box_slab_intersection.sv */
// Top level: box registers, per-stage flow control and the six-stage slab test
// A ray passes through six register stages from request acceptance to out_valid.
// Throughput: one ray per cycle while out_stall is low; each multiply is
// split into two half-width partial products summed in the following stage.
// Each stage advances when it is empty or the stage after it advances.
// Reset (rst_n low, synchronous) clears all stage valid bits and the box to zero.
`include "ray_box_slab_intersection_macros.svh"
module ray_box_slab_intersection import rbsi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_origin_x,
  input  logic signed [COORD_BITS-1:0] in_origin_y,
  input  logic signed [COORD_BITS-1:0] in_origin_z,
  input  logic signed [COORD_BITS-1:0] in_inv_dir_x,
  input  logic signed [COORD_BITS-1:0] in_inv_dir_y,
  input  logic signed [COORD_BITS-1:0] in_inv_dir_z,
  input  logic [COORD_BITS-2:0]        in_ray_limit,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [COORD_BITS-1:0] out_entry_distance
);

  localparam int CB = COORD_BITS;
  localparam int NSTAGE = 6;

  logic signed [CB-1:0] lo_x_r, lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;
  logic [NSTAGE-1:0]    valid_r, valid_nxt;
  logic [NSTAGE-1:0]    en;
  logic [CB-2:0]        lim_r [3];
  slab_en_t             slab_en;
  merge_en_t            merge_en;
  logic signed [CB-1:0] xn, xf, yn, yf, zn, zf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_x_r <= '0;
      lo_y_r <= '0;
      lo_z_r <= '0;
      hi_x_r <= '0;
      hi_y_r <= '0;
      hi_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOX_LOW_X:  lo_x_r <= cfg_data;
        REG_BOX_LOW_Y:  lo_y_r <= cfg_data;
        REG_BOX_LOW_Z:  lo_z_r <= cfg_data;
        REG_BOX_HIGH_X: hi_x_r <= cfg_data;
        REG_BOX_HIGH_Y: hi_y_r <= cfg_data;
        REG_BOX_HIGH_Z: hi_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[NSTAGE-1] = !valid_r[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    for (int k = 0; k < NSTAGE; k++) begin
      if (en[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) lim_r[0] <= in_ray_limit;
    if (en[1]) lim_r[1] <= lim_r[0];
    if (en[2]) lim_r[2] <= lim_r[1];
  end

  assign slab_en  = '{s1: en[0], s2: en[1], s3: en[2]};
  assign merge_en = '{s4: en[3], s5: en[4], s6: en[5]};

  rbsi_slab #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_slab_x (
    .clk(clk), .en(slab_en), .box_lo(lo_x_r), .box_hi(hi_x_r),
    .origin(in_origin_x), .inv_dir(in_inv_dir_x), .near_dist(xn), .far_dist(xf)
  );

  rbsi_slab #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_slab_y (
    .clk(clk), .en(slab_en), .box_lo(lo_y_r), .box_hi(hi_y_r),
    .origin(in_origin_y), .inv_dir(in_inv_dir_y), .near_dist(yn), .far_dist(yf)
  );

  rbsi_slab #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_slab_z (
    .clk(clk), .en(slab_en), .box_lo(lo_z_r), .box_hi(hi_z_r),
    .origin(in_origin_z), .inv_dir(in_inv_dir_z), .near_dist(zn), .far_dist(zf)
  );

  rbsi_merge #(.COORD_BITS(COORD_BITS)) u_merge (
    .clk(clk), .en(merge_en), .xn(xn), .xf(xf), .yn(yn), .yf(yf), .zn(zn), .zf(zf),
    .limit(lim_r[2]), .hit(out_hit), .entry(out_entry_distance)
  );

  assign in_stall  = !en[0];
  assign out_valid = valid_r[NSTAGE-1];

  `RBSI_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, out_entry_distance == '0)
  `RBSI_ASSERT_IMP(a_stall_full, in_stall, &valid_r)
  `RBSI_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, valid_r[0])
  `RBSI_ASSERT_NXT(a_out_held, out_valid && out_stall, out_valid && $stable(out_entry_distance))

endmodule

/* rtl/rbsi_slab.sv */
// One axis: corner differences, split products, floor shift and saturation
module rbsi_slab import rbsi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  slab_en_t                     en,
  input  logic signed [COORD_BITS-1:0] box_lo,
  input  logic signed [COORD_BITS-1:0] box_hi,
  input  logic signed [COORD_BITS-1:0] origin,
  input  logic signed [COORD_BITS-1:0] inv_dir,
  output logic signed [COORD_BITS-1:0] near_dist,
  output logic signed [COORD_BITS-1:0] far_dist
);

  localparam int CB = COORD_BITS;
  localparam int H  = CB / 2;
  localparam int LW = CB + H + 2;
  localparam int HW = 2 * CB - H + 1;
  localparam int PW = 2 * CB + 1;

  logic signed [CB:0]   dn_r, df_r, dn_nxt, df_nxt;
  logic signed [CB-1:0] inv_r;
  logic signed [LW-1:0] pnl_r, pfl_r, pnl_nxt, pfl_nxt;
  logic signed [HW-1:0] pnh_r, pfh_r, pnh_nxt, pfh_nxt;
  logic signed [CB-1:0] near_r, far_r, near_nxt, far_nxt;
  logic signed [CB-1:0] near_c, far_c;

  function automatic logic signed [CB-1:0] scale_sat(input logic signed [LW-1:0] pl,
                                                     input logic signed [HW-1:0] ph);
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sh;
    logic [PW-CB:0]       top;
    prod = PW'(pl) + (PW'(ph) <<< H);
    sh   = prod >>> FRAC_BITS;
    top  = sh[PW-1:CB-1];
    if (top == '0 || top == '1) begin
      scale_sat = sh[CB-1:0];
    end else if (sh[PW-1]) begin
      scale_sat = {1'b1, {(CB-1){1'b0}}};
    end else begin
      scale_sat = {1'b0, {(CB-1){1'b1}}};
    end
  endfunction

  always_comb begin
    near_c  = inv_dir[CB-1] ? box_hi : box_lo;
    far_c   = inv_dir[CB-1] ? box_lo : box_hi;
    dn_nxt  = {near_c[CB-1], near_c} - {origin[CB-1], origin};
    df_nxt  = {far_c[CB-1], far_c} - {origin[CB-1], origin};
    pnl_nxt = dn_r * $signed({1'b0, inv_r[H-1:0]});
    pfl_nxt = df_r * $signed({1'b0, inv_r[H-1:0]});
    pnh_nxt = dn_r * $signed(inv_r[CB-1:H]);
    pfh_nxt = df_r * $signed(inv_r[CB-1:H]);
    near_nxt = scale_sat(pnl_r, pnh_r);
    far_nxt  = scale_sat(pfl_r, pfh_r);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dn_r  <= dn_nxt;
      df_r  <= df_nxt;
      inv_r <= inv_dir;
    end
    if (en.s2) begin
      pnl_r <= pnl_nxt;
      pfl_r <= pfl_nxt;
      pnh_r <= pnh_nxt;
      pfh_r <= pfh_nxt;
    end
    if (en.s3) begin
      near_r <= near_nxt;
      far_r  <= far_nxt;
    end
  end

  assign near_dist = near_r;
  assign far_dist  = far_r;

endmodule

/* rtl/rbsi_merge.sv */
// Interval merge over three axes and the final hit test
module rbsi_merge import rbsi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  merge_en_t                    en,
  input  logic signed [COORD_BITS-1:0] xn,
  input  logic signed [COORD_BITS-1:0] xf,
  input  logic signed [COORD_BITS-1:0] yn,
  input  logic signed [COORD_BITS-1:0] yf,
  input  logic signed [COORD_BITS-1:0] zn,
  input  logic signed [COORD_BITS-1:0] zf,
  input  logic [COORD_BITS-2:0]        limit,
  output logic                         hit,
  output logic signed [COORD_BITS-1:0] entry
);

  localparam int CB = COORD_BITS;

  logic                 miss4_r, miss4_nxt, miss5_r, miss5_nxt, hit_r, hit_nxt;
  logic signed [CB-1:0] tmin4_r, tmax4_r, tmin4_nxt, tmax4_nxt;
  logic signed [CB-1:0] zn4_r, zf4_r;
  logic signed [CB-1:0] tmin5_r, tmax5_r, tmin5_nxt, tmax5_nxt;
  logic signed [CB-1:0] entry_r, entry_nxt;
  logic [CB-2:0]        lim4_r, lim5_r;

  always_comb begin
    miss4_nxt = (xn > yf) || (yn > xf);
    tmin4_nxt = (yn > xn) ? yn : xn;
    tmax4_nxt = (yf < xf) ? yf : xf;
    miss5_nxt = miss4_r || (tmin4_r > zf4_r) || (zn4_r > tmax4_r);
    tmin5_nxt = (zn4_r > tmin4_r) ? zn4_r : tmin4_r;
    tmax5_nxt = (zf4_r < tmax4_r) ? zf4_r : tmax4_r;
    hit_nxt   = !miss5_r && (tmax5_r >= 0) && (tmin5_r < $signed({1'b0, lim5_r}));
    entry_nxt = hit_nxt ? tmin5_r : '0;
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      miss4_r <= miss4_nxt;
      tmin4_r <= tmin4_nxt;
      tmax4_r <= tmax4_nxt;
      zn4_r   <= zn;
      zf4_r   <= zf;
      lim4_r  <= limit;
    end
    if (en.s5) begin
      miss5_r <= miss5_nxt;
      tmin5_r <= tmin5_nxt;
      tmax5_r <= tmax5_nxt;
      lim5_r  <= lim4_r;
    end
    if (en.s6) begin
      hit_r   <= hit_nxt;
      entry_r <= entry_nxt;
    end
  end

  assign hit   = hit_r;
  assign entry = entry_r;

endmodule

/* dv/ray_box_slab_intersection_test.sv */
// Self-checking testbench for the ray/box slab test: queued rays, predicted hits, random flow
module ray_box_slab_intersection_test;
  import rbsi_pkg::*;

  localparam int FRAC = 16;
  localparam int DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RAYS_PER_PHASE = 225;
  localparam logic signed [31:0] SAT_POS = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_NEG = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;
  localparam logic [30:0] LIMIT_MAX = 31'h7fffffff;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [30:0] ray_limit;
    logic [2:0][31:0] inv_dir;
    logic [2:0][31:0] origin;
  } ray_t;

  typedef struct packed {
    logic hit;
    logic [31:0] entry;
  } hit_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0;
  logic signed [31:0] in_origin_y = '0;
  logic signed [31:0] in_origin_z = '0;
  logic signed [31:0] in_inv_dir_x = '0;
  logic signed [31:0] in_inv_dir_y = '0;
  logic signed [31:0] in_inv_dir_z = '0;
  logic [30:0] in_ray_limit = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [31:0] out_entry_distance;

  logic signed [31:0] box_lo [3] = '{0, 0, 0};
  logic signed [31:0] box_hi [3] = '{0, 0, 0};

  ray_t pending_rays [$];
  hit_t predicted_hits [$];
  ray_t on_port;
  hit_t oldest_hit;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int unsigned cycle_count = 0;

  ray_box_slab_intersection dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_origin_x(in_origin_x),
    .in_origin_y(in_origin_y),
    .in_origin_z(in_origin_z),
    .in_inv_dir_x(in_inv_dir_x),
    .in_inv_dir_y(in_inv_dir_y),
    .in_inv_dir_z(in_inv_dir_z),
    .in_ray_limit(in_ray_limit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_entry_distance(out_entry_distance)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] to_fix(input int units);
    return units <<< FRAC;
  endfunction

  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint pick_between(input longint lo, input longint hi);
    logic [63:0] raw;
    longint span;
    span = hi - lo + 1;
    raw = {$urandom, $urandom};
    return lo + longint'(raw % span);
  endfunction

  // (corner - origin) * inverse, floor-shifted and saturated
  function automatic logic signed [31:0] slab_distance(input logic signed [31:0] corner,
                                                       input logic signed [31:0] origin,
                                                       input logic signed [31:0] inv);
    logic signed [95:0] diff;
    logic signed [95:0] prod;
    diff = corner - origin;
    prod = diff * inv;
    prod = prod >>> FRAC;
    if (prod > Q_MAX) return SAT_POS;
    if (prod < Q_MIN) return SAT_NEG;
    return prod[31:0];
  endfunction

  function automatic hit_t trace_ray(input ray_t r);
    longint near_d [3];
    longint far_d [3];
    longint tmin;
    longint tmax;
    logic signed [31:0] inv;
    logic signed [31:0] org;
    hit_t res;
    res = '0;
    for (int a = 0; a < 3; a++) begin
      inv = $signed(r.inv_dir[a]);
      org = $signed(r.origin[a]);
      if (inv >= 0) begin
        near_d[a] = slab_distance(box_lo[a], org, inv);
        far_d[a] = slab_distance(box_hi[a], org, inv);
      end else begin
        near_d[a] = slab_distance(box_hi[a], org, inv);
        far_d[a] = slab_distance(box_lo[a], org, inv);
      end
    end
    tmin = near_d[0];
    tmax = far_d[0];
    for (int a = 1; a < 3; a++) begin
      if (tmin > far_d[a] || near_d[a] > tmax) return res;
      if (near_d[a] > tmin) tmin = near_d[a];
      if (far_d[a] < tmax) tmax = far_d[a];
    end
    if (tmax >= 0 && tmin < longint'(r.ray_limit)) begin
      res.hit = 1'b1;
      res.entry = tmin[31:0];
    end
    return res;
  endfunction

  function automatic void queue_ray(input logic signed [31:0] ox, input logic signed [31:0] oy,
                                    input logic signed [31:0] oz, input logic signed [31:0] ix,
                                    input logic signed [31:0] iy, input logic signed [31:0] iz,
                                    input logic [30:0] lim);
    ray_t r;
    r.origin[0] = ox;
    r.origin[1] = oy;
    r.origin[2] = oz;
    r.inv_dir[0] = ix;
    r.inv_dir[1] = iy;
    r.inv_dir[2] = iz;
    r.ray_limit = lim;
    pending_rays.insert(pending_rays.size(), r);
  endfunction

  // aim most rays at a point of the box, reaching that point at unit distance
  function automatic ray_t random_ray();
    ray_t r;
    longint lo_c;
    longint hi_c;
    longint tgt;
    longint org;
    longint dir;
    longint reach;
    longint inv;
    bit away;
    int sel;
    if ($urandom_range(99) < 25) begin
      for (int a = 0; a < 3; a++) begin
        r.origin[a] = $urandom;
        r.inv_dir[a] = $urandom;
      end
      r.ray_limit = 31'($urandom);
      return r;
    end
    away = ($urandom_range(5) == 0);
    for (int a = 0; a < 3; a++) begin
      lo_c = box_lo[a];
      hi_c = box_hi[a];
      if (lo_c > hi_c) begin
        lo_c = box_hi[a];
        hi_c = box_lo[a];
      end
      tgt = pick_between(lo_c, hi_c);
      reach = longint'(1) << (16 + 4 * $urandom_range(3));
      if ($urandom_range(7) == 0) org = tgt;
      else org = clamp_q(tgt + pick_between(-reach, reach));
      dir = away ? org - tgt : tgt - org;
      if (dir == 0) inv = $urandom_range(1) ? Q_MAX : Q_MIN;
      else inv = clamp_q((longint'(1) << 32) / dir);
      r.origin[a] = org[31:0];
      r.inv_dir[a] = inv[31:0];
    end
    sel = $urandom_range(9);
    if (sel < 4) r.ray_limit = LIMIT_MAX;
    else if (sel == 4) r.ray_limit = '0;
    else if (sel < 8) r.ray_limit = 31'($urandom_range(32'h0100_0000));
    else r.ray_limit = 31'($urandom);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BOX_LOW_X: box_lo[0] = value;
      REG_BOX_LOW_Y: box_lo[1] = value;
      REG_BOX_LOW_Z: box_lo[2] = value;
      REG_BOX_HIGH_X: box_hi[0] = value;
      REG_BOX_HIGH_Y: box_hi[1] = value;
      REG_BOX_HIGH_Z: box_hi[2] = value;
      default: ;
    endcase
  endtask

  task automatic load_box(input logic [31:0] lx, input logic [31:0] ly, input logic [31:0] lz,
                          input logic [31:0] hx, input logic [31:0] hy, input logic [31:0] hz);
    write_reg(REG_BOX_LOW_X, lx);
    write_reg(REG_BOX_LOW_Y, ly);
    write_reg(REG_BOX_LOW_Z, lz);
    write_reg(REG_BOX_HIGH_X, hx);
    write_reg(REG_BOX_HIGH_Y, hy);
    write_reg(REG_BOX_HIGH_Z, hz);
  endtask

  task automatic load_random_box(input longint reach, input bit inverted);
    longint lo [3];
    longint hi [3];
    longint held;
    for (int a = 0; a < 3; a++) begin
      lo[a] = pick_between(-reach, reach);
      hi[a] = clamp_q(lo[a] + pick_between(64'sd4096, reach));
      if (inverted && (a == 0 || $urandom_range(1))) begin
        held = lo[a];
        lo[a] = hi[a];
        hi[a] = held;
      end
    end
    load_box(lo[0][31:0], lo[1][31:0], lo[2][31:0], hi[0][31:0], hi[1][31:0], hi[2][31:0]);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_rays.size() != 0 || in_valid || predicted_hits.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** ray_box_slab_intersection: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predicted_hits.insert(predicted_hits.size(), trace_ray(on_port));
      if (!in_valid || !in_stall) begin
        if (pending_rays.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port = pending_rays.pop_front();
          in_origin_x <= on_port.origin[0];
          in_origin_y <= on_port.origin[1];
          in_origin_z <= on_port.origin[2];
          in_inv_dir_x <= on_port.inv_dir[0];
          in_inv_dir_y <= on_port.inv_dir[1];
          in_inv_dir_z <= on_port.inv_dir[2];
          in_ray_limit <= on_port.ray_limit;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_hits.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          oldest_hit = predicted_hits.pop_front();
          if (out_hit !== oldest_hit.hit)
            report_mismatch($sformatf("hit got %b want %b", out_hit, oldest_hit.hit));
          if (out_entry_distance !== oldest_hit.entry)
            report_mismatch($sformatf("entry_distance got %0d want %0d",
                                      out_entry_distance, $signed(oldest_hit.entry)));
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // box still at reset: a single point at the origin
    queue_ray(0, 0, 0, 0, 0, 0, LIMIT_MAX);
    queue_ray(to_fix(-3), to_fix(1), 0, ONE, 0, 0, LIMIT_MAX);
    queue_ray(0, 0, 0, 0, 0, 0, '0);
    wait_drained();

    load_box(to_fix(-4), to_fix(-2), to_fix(1), to_fix(6), to_fix(3), to_fix(5));
    queue_ray(to_fix(-10), 0, to_fix(3), ONE, SAT_POS, SAT_POS, LIMIT_MAX);
    queue_ray(to_fix(20), 0, to_fix(3), -ONE, SAT_POS, SAT_POS, LIMIT_MAX);
    queue_ray(0, 0, to_fix(3), ONE, ONE, ONE, LIMIT_MAX);
    queue_ray(to_fix(10), 0, to_fix(3), ONE, SAT_POS, SAT_POS, LIMIT_MAX);
    queue_ray(to_fix(-10), to_fix(10), to_fix(3), ONE, ONE, SAT_POS, LIMIT_MAX);
    queue_ray(to_fix(-10), 0, to_fix(20), ONE, SAT_POS, ONE, LIMIT_MAX);
    queue_ray(to_fix(-10), 0, to_fix(3), ONE, SAT_POS, SAT_POS, 31'(to_fix(6)));
    queue_ray(to_fix(-10), 0, to_fix(3), ONE, SAT_POS, SAT_POS, 31'(to_fix(6)) + 31'd1);
    queue_ray(to_fix(-10), 0, to_fix(3), ONE, SAT_POS, SAT_POS, '0);
    queue_ray(to_fix(6), 0, to_fix(3), ONE, SAT_POS, SAT_POS, LIMIT_MAX);
    queue_ray(0, 0, to_fix(3), 0, 0, 0, LIMIT_MAX);
    queue_ray(to_fix(-10), 0, to_fix(3), 0, 0, 0, LIMIT_MAX);
    queue_ray(to_fix(-10), to_fix(-1), to_fix(3), 32'sh8000, 32'sh20000, -32'sh30000, LIMIT_MAX);
    queue_ray(SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, SAT_POS, LIMIT_MAX);
    queue_ray(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, '0);
    queue_ray(SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS, SAT_POS, SAT_POS, LIMIT_MAX);
    queue_ray(SAT_POS, SAT_POS, SAT_POS, SAT_NEG, SAT_NEG, SAT_NEG, LIMIT_MAX);
    queue_ray(-1, -1, -1, -1, -1, -1, 31'd1);
    queue_ray(to_fix(10) + 1, 0, to_fix(3), 32'sd3, SAT_POS, SAT_POS, LIMIT_MAX);
    queue_ray(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
              32'haaaaaaaa, 31'h2aaaaaaa);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: load_random_box(64'sd1 << 22, 1'b0);
        1: load_box(SAT_NEG, SAT_NEG, SAT_NEG, SAT_POS, SAT_POS, SAT_POS);
        2: begin
          load_random_box(64'sd1 << 24, 1'b1);
          write_reg(REG_SPARE_6, $urandom);
          write_reg(REG_SPARE_7, $urandom);
        end
        3: load_random_box(64'sd1 << 16, 1'b0);
        default: load_random_box(Q_MAX, 1'b0);
      endcase
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 64;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 64;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct = 19;
        end
      endcase
      repeat (RAYS_PER_PHASE) pending_rays.insert(pending_rays.size(), random_ray());
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("** ray_box_slab_intersection: PASSED **");
    end else begin
      $display("** ray_box_slab_intersection: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/rbsi_pkg.sv
rtl/rbsi_slab.sv
rtl/rbsi_merge.sv
rtl/ray_box_slab_intersection.sv
dv/ray_box_slab_intersection_test.sv
